/* rtl/elevator_car_controller_top_assert.svh */
// Assertion macros for the elevator car controller.
// Used by the top level only; needs no package.
`ifndef ELEVATOR_CAR_CONTROLLER_TOP_ASSERT_SVH
`define ELEVATOR_CAR_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ECC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("elevator car controller: assertion failed");

// Next-cycle implication, disabled during reset
`define ECC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("elevator car controller: assertion failed");

`endif

/* rtl/ecc_pkg.sv */
// Shared types, codes and helpers for the elevator car controller.
// No dependencies; imported by every module of the block.
package ecc_pkg;

   // Shaft size
   localparam int FLOOR_COUNT = 8;
   localparam int FloorW      = $clog2(FLOOR_COUNT);

   // Event codes
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_REQUEST   = 3'd1;
   localparam logic [2:0] OP_EMERG     = 3'd2;
   localparam logic [2:0] OP_CLEAR     = 3'd3;
   localparam logic [2:0] OP_AT_FLOOR  = 3'd4;

   // Car state codes as seen on the result
   localparam logic [2:0] CAR_IDLE     = 3'd0;
   localparam logic [2:0] CAR_UP       = 3'd1;
   localparam logic [2:0] CAR_DOWN     = 3'd2;
   localparam logic [2:0] CAR_DOORS    = 3'd3;
   localparam logic [2:0] CAR_EMERG    = 3'd4;

   // Direction codes
   localparam logic [1:0] HEAD_NONE    = 2'd0;
   localparam logic [1:0] HEAD_UP      = 2'd1;
   localparam logic [1:0] HEAD_DOWN    = 2'd2;

   // Motor codes
   localparam logic [1:0] DRIVE_STOP   = 2'd0;
   localparam logic [1:0] DRIVE_SLOW   = 2'd1;
   localparam logic [1:0] DRIVE_FULL   = 2'd2;

   // Register map
   localparam int CSR_COUNT = 2;
   localparam int CsrIdxW   = $clog2(CSR_COUNT);
   localparam logic [CsrIdxW-1:0] CSR_TRANSIT = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CSR_DOOR    = CsrIdxW'(1);

   localparam logic [7:0] TRANSIT_RESET = 8'd5;
   localparam logic [7:0] DOOR_RESET    = 8'd3;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] floor;
   } req_type;

   typedef struct packed {
      logic [2:0]             car_state;
      logic [FloorW-1:0]      current_floor;
      logic [FloorW-1:0]      target_floor;
      logic                   target_valid;
      logic [1:0]             travel_direction;
      logic [1:0]             motor_command;
      logic [FLOOR_COUNT-1:0] pending_requests;
   } rsp_type;

   typedef struct packed {
      logic [7:0] transit_ticks;
      logic [7:0] door_ticks;
   } cfg_type;

   // One-hot mask for a floor
   function automatic logic [FLOOR_COUNT-1:0] floor_mask(input logic [FloorW-1:0] f);
      logic [FLOOR_COUNT-1:0] m;
      m    = '0;
      m[f] = 1'b1;
      return m;
   endfunction

endpackage

/* rtl/ecc_target.sv */
// Target floor picker: directional scan with nearest-floor fallback.
// Depends on ecc_pkg.
module ecc_target (
   input  logic [ecc_pkg::FLOOR_COUNT-1:0] req_bits,
   input  logic [ecc_pkg::FloorW-1:0]      floor_now,
   input  logic [1:0]                      heading,
   output logic [ecc_pkg::FloorW-1:0]      target
);
   import ecc_pkg::*;

   logic              up_found, dn_found, near_found;
   logic [FloorW-1:0] up_floor, dn_floor, near_floor;

   always_comb begin
      logic [FloorW-1:0] fv;
      logic [FloorW-1:0] span;
      logic [FloorW-1:0] best_dist;
      up_found   = 1'b0;
      dn_found   = 1'b0;
      near_found = 1'b0;
      up_floor   = '0;
      dn_floor   = '0;
      near_floor = '0;
      best_dist  = '0;
      fv         = '0;
      span       = '0;

      // lowest requested floor at or above the car
      for (int f = FLOOR_COUNT - 1; f >= 0; f--) begin
         if (req_bits[f] && (FloorW'(f) >= floor_now)) begin
            up_found = 1'b1;
            up_floor = FloorW'(f);
         end
      end

      // highest requested floor at or below the car
      for (int f = 0; f < FLOOR_COUNT; f++) begin
         if (req_bits[f] && (FloorW'(f) <= floor_now)) begin
            dn_found = 1'b1;
            dn_floor = FloorW'(f);
         end
      end

      // nearest requested floor, strict compare keeps the lower on a tie
      for (int f = 0; f < FLOOR_COUNT; f++) begin
         fv   = FloorW'(f);
         span = (fv > floor_now) ? (fv - floor_now) : (floor_now - fv);
         if (req_bits[f] && (!near_found || (span < best_dist))) begin
            near_found = 1'b1;
            best_dist  = span;
            near_floor = fv;
         end
      end

      if ((heading == HEAD_UP) && up_found) begin
         target = up_floor;
      end else if ((heading == HEAD_DOWN) && dn_found) begin
         target = dn_floor;
      end else begin
         target = near_floor;
      end
   end

endmodule

/* rtl/ecc_core.sv */
// Car state machine: applies one event to the car state per step.
// Depends on ecc_pkg and ecc_target.
module ecc_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  ecc_pkg::req_type item,
   input  ecc_pkg::cfg_type cfg,
   output ecc_pkg::rsp_type result
);
   import ecc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = CAR_IDLE,
      ST_UP    = CAR_UP,
      ST_DOWN  = CAR_DOWN,
      ST_DOORS = CAR_DOORS,
      ST_EMERG = CAR_EMERG
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [FloorW-1:0]      now_ff, now_in;
   logic [FloorW-1:0]      goal_ff, goal_in;
   logic                   goal_set_ff, goal_set_in;
   logic [1:0]             heading_ff, heading_in;
   logic [FLOOR_COUNT-1:0] req_ff, req_in;
   logic                   halt_ff, halt_in;
   logic [7:0]             dc_ff, dc_in;
   logic [7:0]             tc_ff, tc_in;
   logic                   dt_ff, dt_in;
   logic                   tt_ff, tt_in;
   logic [1:0]             drive_ff, drive_in;

   logic [FloorW-1:0]      pick;
   logic [1:0]             pick_heading;
   logic                   going_up;
   logic                   last_leg;
   logic [FloorW-1:0]      moved;
   logic                   floor_ok;

   // idle always searches for the nearest floor
   assign pick_heading = (mode_ff == ST_IDLE) ? HEAD_NONE : heading_ff;

   ecc_target u_target (
      .req_bits  (req_ff),
      .floor_now (now_ff),
      .heading   (pick_heading),
      .target    (pick)
   );

   // travel helpers
   assign going_up = (mode_ff == ST_UP);
   assign floor_ok = (item.floor < 8'(FLOOR_COUNT));

   always_comb begin
      if (going_up) begin
         last_leg = (({1'b0, now_ff} + 1'b1) == {1'b0, goal_ff});
         moved    = (now_ff != FloorW'(FLOOR_COUNT - 1)) ? now_ff + 1'b1 : now_ff;
      end else begin
         last_leg = (now_ff != '0) && ((now_ff - 1'b1) == goal_ff);
         moved    = (now_ff != '0) ? now_ff - 1'b1 : now_ff;
      end
   end

   // next state
   always_comb begin
      mode_in     = mode_ff;
      now_in      = now_ff;
      goal_in     = goal_ff;
      goal_set_in = goal_set_ff;
      heading_in  = heading_ff;
      req_in      = req_ff;
      halt_in     = halt_ff;
      dc_in       = dc_ff;
      tc_in       = tc_ff;
      dt_in       = dt_ff;
      tt_in       = tt_ff;
      drive_in    = drive_ff;

      if (step) begin
         case (item.operation)
            OP_TICK: begin
               if (halt_ff) begin
                  drive_in = DRIVE_STOP;
                  mode_in  = ST_EMERG;
               end else begin
                  case (mode_ff)
                     ST_IDLE: begin
                        drive_in   = DRIVE_STOP;
                        heading_in = HEAD_NONE;
                        if (|req_ff) begin
                           goal_in     = pick;
                           goal_set_in = 1'b1;
                           if (pick == now_ff) begin
                              req_in  = req_ff & ~floor_mask(now_ff);
                              mode_in = ST_DOORS;
                              dc_in   = '0;
                              dt_in   = 1'b1;
                           end else if (pick < now_ff) begin
                              heading_in = HEAD_DOWN;
                              mode_in    = ST_DOWN;
                              tc_in      = '0;
                              tt_in      = 1'b1;
                              drive_in   = DRIVE_FULL;
                           end else begin
                              heading_in = HEAD_UP;
                              mode_in    = ST_UP;
                              tc_in      = '0;
                              tt_in      = 1'b1;
                              drive_in   = DRIVE_FULL;
                           end
                        end
                     end
                     ST_UP, ST_DOWN: begin
                        if (tt_ff) begin
                           tc_in = tc_ff + 8'd1;
                           if (last_leg && (tc_in >= (cfg.transit_ticks >> 1))) begin
                              drive_in = DRIVE_SLOW;
                           end
                           // one floor of travel done
                           if (tc_in >= cfg.transit_ticks) begin
                              now_in = moved;
                              tc_in  = '0;
                              if (req_ff[moved]) begin
                                 req_in   = req_ff & ~floor_mask(moved);
                                 mode_in  = ST_DOORS;
                                 dc_in    = '0;
                                 dt_in    = 1'b1;
                                 tt_in    = 1'b0;
                                 drive_in = DRIVE_STOP;
                              end else if (going_up ? (moved >= goal_ff)
                                                    : (moved <= goal_ff)) begin
                                 mode_in     = ST_IDLE;
                                 tt_in       = 1'b0;
                                 goal_set_in = 1'b0;
                                 goal_in     = '0;
                                 drive_in    = DRIVE_STOP;
                              end else begin
                                 drive_in = DRIVE_FULL;
                              end
                           end
                        end
                     end
                     ST_DOORS: begin
                        drive_in = DRIVE_STOP;
                        if (dt_ff) begin
                           dc_in = dc_ff + 8'd1;
                           if (dc_in >= cfg.door_ticks) begin
                              dt_in = 1'b0;
                              dc_in = '0;
                              if (|req_ff) begin
                                 goal_in     = pick;
                                 goal_set_in = 1'b1;
                                 if (pick > now_ff) begin
                                    heading_in = HEAD_UP;
                                    mode_in    = ST_UP;
                                    tc_in      = '0;
                                    tt_in      = 1'b1;
                                    drive_in   = DRIVE_FULL;
                                 end else if (pick < now_ff) begin
                                    heading_in = HEAD_DOWN;
                                    mode_in    = ST_DOWN;
                                    tc_in      = '0;
                                    tt_in      = 1'b1;
                                    drive_in   = DRIVE_FULL;
                                 end else begin
                                    // request at this floor: hold the doors again
                                    req_in = req_ff & ~floor_mask(now_ff);
                                    dc_in  = '0;
                                    dt_in  = 1'b1;
                                 end
                              end else begin
                                 mode_in     = ST_IDLE;
                                 goal_set_in = 1'b0;
                                 goal_in     = '0;
                                 heading_in  = HEAD_NONE;
                              end
                           end
                        end
                     end
                     default: begin
                        drive_in = DRIVE_STOP;
                        mode_in  = ST_EMERG;
                     end
                  endcase
               end
            end
            OP_REQUEST: begin
               if (floor_ok) begin
                  req_in = req_ff | floor_mask(item.floor[FloorW-1:0]);
               end
            end
            OP_EMERG: begin
               halt_in  = 1'b1;
               mode_in  = ST_EMERG;
               drive_in = DRIVE_STOP;
            end
            OP_CLEAR: begin
               halt_in = 1'b0;
               mode_in = ST_IDLE;
            end
            OP_AT_FLOOR: begin
               if (floor_ok) begin
                  now_in = item.floor[FloorW-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result view of the updated state
   always_comb begin
      result.car_state        = mode_in;
      result.current_floor    = now_in;
      result.target_floor     = goal_set_in ? goal_in : '0;
      result.target_valid     = goal_set_in;
      result.travel_direction = heading_in;
      result.motor_command    = drive_in;
      result.pending_requests = req_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ST_IDLE;
         now_ff      <= '0;
         goal_ff     <= '0;
         goal_set_ff <= 1'b0;
         heading_ff  <= HEAD_NONE;
         req_ff      <= '0;
         halt_ff     <= 1'b0;
         dc_ff       <= '0;
         tc_ff       <= '0;
         dt_ff       <= 1'b0;
         tt_ff       <= 1'b0;
         drive_ff    <= DRIVE_STOP;
      end else begin
         mode_ff     <= mode_in;
         now_ff      <= now_in;
         goal_ff     <= goal_in;
         goal_set_ff <= goal_set_in;
         heading_ff  <= heading_in;
         req_ff      <= req_in;
         halt_ff     <= halt_in;
         dc_ff       <= dc_in;
         tc_ff       <= tc_in;
         dt_ff       <= dt_in;
         tt_ff       <= tt_in;
         drive_ff    <= drive_in;
      end
   end

endmodule

/* rtl/elevator_car_controller_top.sv */
// Top level of the elevator car controller: channels, registers, pipeline.
// Depends on ecc_pkg, ecc_core and elevator_car_controller_top_assert.svh.
//
// Usage:
//   req_*  : one event per beat (tick, request, emergency stop/clear,
//            floor reached). Accepted when req_valid is high and req_stall low.
//   rsp_*  : one result beat per event: car state, floors, direction, motor
//            command and pending request mask after that event.
//   csr_*  : register writes (0 transit_ticks, 1 door_ticks); csr_ready is
//            always high. Write only while no event is in flight.
// Path: an accepted event beat passes an input register, then the result
//   register, which takes the state update.
// Throughput: one event per cycle unless stalled; combinational state update.
// Stall: when rsp_stall holds a waiting result, the input register still
//   takes one more beat; req_stall rises only when both stages are full.
// Reset: synchronous, active high. Car idle at floor 0, no requests, no
//   target, motor stopped, transit_ticks 5, door_ticks 3, both stages empty.
module elevator_car_controller_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ecc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ecc_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ecc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [7:0]                csr_data
);
   import ecc_pkg::*;

   `include "elevator_car_controller_top_assert.svh"

   cfg_type cfg_ff, cfg_in;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_result;
   logic    load_rsp;
   logic    take_req;
   logic    rsp_stopped;
   logic    rsp_moving;
   logic    rsp_motor_off;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRANSIT: cfg_in.transit_ticks = csr_data;
            CSR_DOOR:    cfg_in.door_ticks    = csr_data;
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   assign load_rsp    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !load_rsp;
   assign take_req    = req_valid && !req_stall;
   assign in_valid_in = take_req || (in_valid_ff && !load_rsp);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   ecc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (load_rsp),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transit_ticks <= TRANSIT_RESET;
         cfg_ff.door_ticks    <= DOOR_RESET;
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // result state classes for the checks
   assign rsp_stopped   = (rsp_data.car_state == CAR_DOORS) ||
                          (rsp_data.car_state == CAR_EMERG);
   assign rsp_moving    = (rsp_data.car_state == CAR_UP) ||
                          (rsp_data.car_state == CAR_DOWN);
   assign rsp_motor_off = (rsp_data.motor_command == DRIVE_STOP);

   // checks
   `ECC_ASSERT_IMPL(a_stall_needs_item, clock, reset, req_stall, in_valid_ff)
   `ECC_ASSERT_NEXT(a_item_reaches_rsp, clock, reset, in_valid_ff && !rsp_valid_ff, rsp_valid_ff)
   `ECC_ASSERT_IMPL(a_stopped_states, clock, reset, rsp_valid && rsp_stopped, rsp_motor_off)
   `ECC_ASSERT_IMPL(a_moving_drives, clock, reset, rsp_valid && rsp_moving, !rsp_motor_off)

endmodule

/* test/elevator_car_controller_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for elevator_car_controller_top: directed and random car events, with a
// scoreboard class that predicts each status beat. Depends on ecc_pkg and the RTL only.
module elevator_car_controller_top_tb;
   import ecc_pkg::*;

   // Event codes the block treats as no-ops
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int PHASES       = 8;
   localparam int PHASE_EVENTS = 145;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 40;

   // Car model plus the queue of status beats still owed by the block
   class car_scoreboard;
      logic [7:0]             transit_ticks;
      logic [7:0]             door_ticks;
      logic [2:0]             mode;
      logic [FloorW-1:0]      floor_now;
      logic [FloorW-1:0]      floor_goal;
      logic                   goal_set;
      logic [1:0]             heading;
      logic [1:0]             drive;
      logic [FLOOR_COUNT-1:0] requests;
      logic                   halt;
      logic [7:0]             door_count;
      logic [7:0]             travel_count;
      logic                   door_timing;
      logic                   travel_timing;
      rsp_type                expected_status[$];
      int                     mismatch_count;

      function new();
         transit_ticks  = TRANSIT_RESET;
         door_ticks     = DOOR_RESET;
         mode           = CAR_IDLE;
         floor_now      = '0;
         floor_goal     = '0;
         goal_set       = 1'b0;
         heading        = HEAD_NONE;
         drive          = DRIVE_STOP;
         requests       = '0;
         halt           = 1'b0;
         door_count     = '0;
         travel_count   = '0;
         door_timing    = 1'b0;
         travel_timing  = 1'b0;
         mismatch_count = 0;
      endfunction

      function void configure(logic [CsrIdxW-1:0] idx, logic [7:0] value);
         if (idx == CSR_TRANSIT)
            transit_ticks = value;
         else if (idx == CSR_DOOR)
            door_ticks = value;
      endfunction

      // Scan along the heading first, then nearest floor (ties go low)
      function bit pick_target(output logic [FloorW-1:0] dest);
         int here;
         int f;
         int span;
         int best_dist;
         here        = int'(floor_now);
         best_dist   = 256;
         dest        = '0;
         pick_target = 1'b0;
         if (heading == HEAD_UP)
            for (f = here; f < FLOOR_COUNT; f++)
               if (requests[f]) begin
                  dest = FloorW'(f);
                  return 1'b1;
               end
         if (heading == HEAD_DOWN)
            for (f = here; f >= 0; f--)
               if (requests[f]) begin
                  dest = FloorW'(f);
                  return 1'b1;
               end
         for (f = 0; f < FLOOR_COUNT; f++)
            if (requests[f]) begin
               span = (f > here) ? f - here : here - f;
               if (span < best_dist) begin
                  best_dist   = span;
                  dest        = FloorW'(f);
                  pick_target = 1'b1;
               end
            end
      endfunction

      function void open_doors();
         requests[floor_now] = 1'b0;
         mode                = CAR_DOORS;
         door_count          = '0;
         door_timing         = 1'b1;
      endfunction

      function void start_move(logic [2:0] next_mode, logic [1:0] dir);
         heading       = dir;
         mode          = next_mode;
         travel_count  = '0;
         travel_timing = 1'b1;
         drive         = DRIVE_FULL;
      endfunction

      // One tick of travel; floor changes once the transit count expires
      function void move_tick(bit up);
         bit last_leg;
         if (!travel_timing)
            return;
         travel_count = travel_count + 8'd1;
         if (up)
            last_leg = (int'(floor_now) + 1 == int'(floor_goal));
         else
            last_leg = (floor_now > 0) && (int'(floor_now) - 1 == int'(floor_goal));
         if (last_leg && travel_count >= transit_ticks / 2)
            drive = DRIVE_SLOW;
         if (travel_count < transit_ticks)
            return;
         // Held at the shaft ends
         if (up) begin
            if (int'(floor_now) + 1 < FLOOR_COUNT)
               floor_now = floor_now + 1'b1;
         end else if (floor_now > 0) begin
            floor_now = floor_now - 1'b1;
         end
         travel_count = '0;
         if (requests[floor_now]) begin
            open_doors();
            travel_timing = 1'b0;
            drive         = DRIVE_STOP;
         end else if (up ? (floor_now >= floor_goal) : (floor_now <= floor_goal)) begin
            mode          = CAR_IDLE;
            travel_timing = 1'b0;
            goal_set      = 1'b0;
            floor_goal    = '0;
            drive         = DRIVE_STOP;
         end else begin
            drive = DRIVE_FULL;
         end
      endfunction

      function void tick_car();
         logic [FloorW-1:0] t;
         if (halt) begin
            drive = DRIVE_STOP;
            mode  = CAR_EMERG;
            return;
         end
         case (mode)
            CAR_IDLE: begin
               drive   = DRIVE_STOP;
               heading = HEAD_NONE;
               if (pick_target(t)) begin
                  floor_goal = t;
                  goal_set   = 1'b1;
                  if (t == floor_now)
                     open_doors();
                  else if (t < floor_now)
                     start_move(CAR_DOWN, HEAD_DOWN);
                  else
                     start_move(CAR_UP, HEAD_UP);
               end
            end
            CAR_UP:   move_tick(1'b1);
            CAR_DOWN: move_tick(1'b0);
            CAR_DOORS: begin
               drive = DRIVE_STOP;
               if (door_timing) begin
                  door_count = door_count + 8'd1;
                  if (door_count >= door_ticks) begin
                     door_timing = 1'b0;
                     door_count  = '0;
                     if (pick_target(t)) begin
                        floor_goal = t;
                        goal_set   = 1'b1;
                        if (t > floor_now)
                           start_move(CAR_UP, HEAD_UP);
                        else if (t < floor_now)
                           start_move(CAR_DOWN, HEAD_DOWN);
                        else begin
                           // new call at this floor: keep the doors open
                           requests[floor_now] = 1'b0;
                           door_count          = '0;
                           door_timing         = 1'b1;
                        end
                     end else begin
                        mode       = CAR_IDLE;
                        goal_set   = 1'b0;
                        floor_goal = '0;
                        heading    = HEAD_NONE;
                     end
                  end
               end
            end
            default: begin
               drive = DRIVE_STOP;
               mode  = CAR_EMERG;
            end
         endcase
      endfunction

      // Apply one accepted event and queue the status it should produce
      function void note_event(req_type ev);
         rsp_type s;
         case (ev.operation)
            OP_TICK: tick_car();
            OP_REQUEST:
               if (ev.floor < FLOOR_COUNT)
                  requests[ev.floor[FloorW-1:0]] = 1'b1;
            OP_EMERG: begin
               halt  = 1'b1;
               mode  = CAR_EMERG;
               drive = DRIVE_STOP;
            end
            OP_CLEAR: begin
               halt = 1'b0;
               mode = CAR_IDLE;
            end
            OP_AT_FLOOR:
               if (ev.floor < FLOOR_COUNT)
                  floor_now = ev.floor[FloorW-1:0];
            default: ;
         endcase
         s.car_state        = mode;
         s.current_floor    = floor_now;
         s.target_floor     = goal_set ? floor_goal : '0;
         s.target_valid     = goal_set;
         s.travel_direction = heading;
         s.motor_command    = drive;
         s.pending_requests = requests;
         expected_status.push_back(s);
      endfunction

      task report(string msg);
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT)
            $display("tb: mismatch at %0t: %s", $time, msg);
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_status(rsp_type got);
         rsp_type want;
         if (expected_status.size() == 0) begin
            report("status beat with nothing expected");
            return;
         end
         want = expected_status.pop_front();
         compare_field("car_state", 8'(got.car_state), 8'(want.car_state));
         compare_field("current_floor", 8'(got.current_floor), 8'(want.current_floor));
         compare_field("target_floor", 8'(got.target_floor), 8'(want.target_floor));
         compare_field("target_valid", 8'(got.target_valid), 8'(want.target_valid));
         compare_field("travel_direction", 8'(got.travel_direction),
                       8'(want.travel_direction));
         compare_field("motor_command", 8'(got.motor_command), 8'(want.motor_command));
         compare_field("pending_requests", 8'(got.pending_requests),
                       8'(want.pending_requests));
      endtask
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [7:0]         csr_data  = '0;

   car_scoreboard sb = new();

   bit send_gaps     = 1'b1;
   bit recv_gaps     = 1'b1;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   elevator_car_controller_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = holds_served + 1;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= recv_gaps && ($urandom_range(99) < 23);
      end
   end

   // Status monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_status(rsp_data);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // One event beat, with random idle cycles ahead of it
   task automatic send_event(input logic [2:0] op, input logic [7:0] fl);
      req_type ev;
      ev.operation = op;
      ev.floor     = fl;
      while (send_gaps && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      sb.note_event(ev);
   endtask

   // Caller lowers csr_valid after the last write
   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.configure(idx, value);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_status.size() != 0)
         @(posedge clock);
   endtask

   // Mostly ticks and in-range calls; returns 0 for beats the block ignores
   function automatic bit random_event(output logic [2:0] op, output logic [7:0] fl);
      int roll;
      roll         = $urandom_range(99);
      fl           = 8'($urandom_range(255));
      random_event = 1'b1;
      if (roll < 52) begin
         op = OP_TICK;
      end else if (roll < 74) begin
         op = OP_REQUEST;
         if (roll < 72)
            fl = 8'($urandom_range(FLOOR_COUNT - 1));
         else
            random_event = (fl < FLOOR_COUNT);
      end else if (roll < 80) begin
         op = OP_AT_FLOOR;
         if (roll < 79)
            fl = 8'($urandom_range(FLOOR_COUNT - 1));
         else
            random_event = (fl < FLOOR_COUNT);
      end else if (roll < 83) begin
         op = OP_EMERG;
      end else if (roll < 87) begin
         op = OP_CLEAR;
      end else if (roll < 90) begin
         op           = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
         random_event = 1'b0;
      end else begin
         op = OP_TICK;
      end
   endfunction

   // Reset-value timing: field extremes, no-op codes, shaft ends, emergency
   task automatic directed_events();
      send_event(OP_TICK, 8'h00);
      send_event(OP_SPARE_LO, 8'hAA);
      send_event(OP_SPARE_HI, 8'h55);
      send_event(OP_REQUEST, 8'hFF);
      send_event(OP_AT_FLOOR, 8'(FLOOR_COUNT));
      // call at the current floor opens the doors at once
      send_event(OP_REQUEST, 8'h00);
      send_event(OP_TICK, 8'hFF);
      send_event(OP_REQUEST, 8'(FLOOR_COUNT - 1));
      repeat (3) send_event(OP_TICK, 8'h00);
      // sensor puts the car at the top while it is still moving up
      send_event(OP_AT_FLOOR, 8'(FLOOR_COUNT - 1));
      repeat (5) send_event(OP_TICK, 8'h00);
      send_event(OP_EMERG, 8'h00);
      send_event(OP_TICK, 8'h00);
      send_event(OP_REQUEST, 8'h03);
      send_event(OP_AT_FLOOR, 8'h00);
      send_event(OP_CLEAR, 8'h00);
      send_event(OP_TICK, 8'h00);
      send_event(OP_TICK, 8'h00);
   endtask

   initial begin
      int         p;
      int         counted;
      logic [2:0] op;
      logic [7:0] fl;
      logic [7:0] transit_set [PHASES];
      logic [7:0] door_set [PHASES];
      transit_set    = '{8'd1, 8'd255, 8'd2, 8'd3, 8'd1, 8'd255, 8'd1, 8'd4};
      door_set       = '{8'd1, 8'd255, 8'd1, 8'd2, 8'd255, 8'd1, 8'd1, 8'd6};
      transit_set[6] = 8'($urandom_range(8, 1));
      door_set[6]    = 8'($urandom_range(8, 1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed_events();

      for (p = 0; p < PHASES; p++) begin
         // sender pauses here until every status beat is back
         wait_drained();
         write_csr(CSR_TRANSIT, transit_set[p]);
         write_csr(CSR_DOOR, door_set[p]);
         csr_valid <= 1'b0;
         // phase 2 runs with no idling on either side
         send_gaps = (p != 2);
         recv_gaps = (p != 2);
         counted   = 0;
         while (counted < PHASE_EVENTS) begin
            // long receiver hold-off while events keep coming
            if (p == 4 && counted == 30 && hold_requests == 0)
               hold_requests++;
            if (random_event(op, fl))
               counted++;
            send_event(op, fl);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/ecc_pkg.sv
rtl/ecc_target.sv
rtl/ecc_core.sv
rtl/elevator_car_controller_top.sv
test/elevator_car_controller_top_tb.sv
